FILE: design/cosine_taylor_series_core_defines.svh
// cosine_taylor_series_core_defines.svh
// Assertion macros for the cosine core checkers; no dependencies.
`ifndef COSINE_TAYLOR_SERIES_CORE_DEFINES_SVH
`define COSINE_TAYLOR_SERIES_CORE_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define CTS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CTS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/cts_pkg.sv
// cts_pkg.sv
// Formats, constant tables and microcode program of the cosine core.
// No dependencies.
package cts_pkg;

	localparam int MAX_TERMS       = 16;
	localparam int ANGLE_FRAC_BITS = 24;
	localparam int Q_FRAC          = 40;

	localparam int ANGLE_W = 32;
	localparam int COS_W   = 32;
	localparam int CFG_W   = 5;

	// |x| <= 2^(X_W-1); quotient by 2*pi stays below 2^RED_STEPS
	localparam int X_W       = ANGLE_W + Q_FRAC - ANGLE_FRAC_BITS;
	localparam int RED_STEPS = X_W - 43;

	// |r| < 2^43, r^2 < 2^46, |t*r^2| < 2^52, |t| < 2^47, |sum| < 2^50
	localparam int R2_W   = 46;
	localparam int NUM_W  = 52;
	localparam int TERM_W = 48;
	localparam int SUM_W  = 52;
	localparam int MUL_W  = 32;
	localparam int OPD_W  = 2 * MUL_W;
	localparam int ACC_W  = 2 * OPD_W;
	localparam int RND_SH = Q_FRAC - (COS_W - 2);
	localparam int TBL_IW = 5;

	localparam int CNT_W = ($clog2(MAX_TERMS + 1) > $clog2(RED_STEPS)) ?
		$clog2(MAX_TERMS + 1) : $clog2(RED_STEPS);

	localparam logic [42:0]          TWO_PI_Q40  = 43'h6487ED5110B;
	localparam logic [SUM_W-1:0]     ONE_Q40     = SUM_W'(1) << Q_FRAC;
	localparam logic [CFG_W-1:0]     TERMS_RESET = CFG_W'(16);
	localparam logic [OPD_W-1:0]     Q64_ONES    = '1;

	// ceil(2^64 / (2k(2k-1))): exact floor division for dividends below 2^52
	localparam logic [OPD_W-1:0] RECIP_TBL [32] = '{
		64'd0,
		Q64_ONES / 64'd2    + 64'd1, Q64_ONES / 64'd12   + 64'd1,
		Q64_ONES / 64'd30   + 64'd1, Q64_ONES / 64'd56   + 64'd1,
		Q64_ONES / 64'd90   + 64'd1, Q64_ONES / 64'd132  + 64'd1,
		Q64_ONES / 64'd182  + 64'd1, Q64_ONES / 64'd240  + 64'd1,
		Q64_ONES / 64'd306  + 64'd1, Q64_ONES / 64'd380  + 64'd1,
		Q64_ONES / 64'd462  + 64'd1, Q64_ONES / 64'd552  + 64'd1,
		Q64_ONES / 64'd650  + 64'd1, Q64_ONES / 64'd756  + 64'd1,
		Q64_ONES / 64'd870  + 64'd1, Q64_ONES / 64'd992  + 64'd1,
		Q64_ONES / 64'd1122 + 64'd1, Q64_ONES / 64'd1260 + 64'd1,
		Q64_ONES / 64'd1406 + 64'd1, Q64_ONES / 64'd1560 + 64'd1,
		Q64_ONES / 64'd1722 + 64'd1, Q64_ONES / 64'd1892 + 64'd1,
		Q64_ONES / 64'd2070 + 64'd1, Q64_ONES / 64'd2256 + 64'd1,
		Q64_ONES / 64'd2450 + 64'd1, Q64_ONES / 64'd2652 + 64'd1,
		Q64_ONES / 64'd2862 + 64'd1, Q64_ONES / 64'd3080 + 64'd1,
		Q64_ONES / 64'd3306 + 64'd1, Q64_ONES / 64'd3540 + 64'd1,
		Q64_ONES / 64'd3782 + 64'd1
	};

	// half divisor k(2k-1), added for round to nearest
	localparam logic [11:0] HALF_D_TBL [32] = '{
		12'd0,    12'd1,    12'd6,    12'd15,   12'd28,   12'd45,   12'd66,   12'd91,
		12'd120,  12'd153,  12'd190,  12'd231,  12'd276,  12'd325,  12'd378,  12'd435,
		12'd496,  12'd561,  12'd630,  12'd703,  12'd780,  12'd861,  12'd946,  12'd1035,
		12'd1128, 12'd1225, 12'd1326, 12'd1431, 12'd1540, 12'd1653, 12'd1770, 12'd1891
	};

	typedef logic [2:0] op_t;
	typedef logic [2:0] jmp_t;
	typedef logic [1:0] sel_t;
	typedef logic [4:0] pc_t;

	localparam op_t OP_NOP  = 3'd0;
	localparam op_t OP_LOAD = 3'd1;
	localparam op_t OP_RED  = 3'd2;
	localparam op_t OP_R2   = 3'd3;
	localparam op_t OP_NUM  = 3'd4;
	localparam op_t OP_TERM = 3'd5;
	localparam op_t OP_FIN  = 3'd6;

	localparam jmp_t J_NEXT     = 3'd0;
	localparam jmp_t J_WAIT_IN  = 3'd1;
	localparam jmp_t J_RED      = 3'd2;
	localparam jmp_t J_ONE_TERM = 3'd3;
	localparam jmp_t J_LOOP     = 3'd4;
	localparam jmp_t J_WAIT_OUT = 3'd5;

	localparam sel_t A_REM  = 2'd0;
	localparam sel_t A_TERM = 2'd1;
	localparam sel_t A_NUM  = 2'd2;

	localparam sel_t B_REM   = 2'd0;
	localparam sel_t B_R2    = 2'd1;
	localparam sel_t B_RECIP = 2'd2;

	localparam pc_t PC_IDLE     = 5'd0;
	localparam pc_t PC_RED      = 5'd1;
	localparam pc_t PC_RSQ      = 5'd2;
	localparam pc_t PC_RSQ_END  = 5'd6;
	localparam pc_t PC_R2       = 5'd7;
	localparam pc_t PC_LOOP     = 5'd8;
	localparam pc_t PC_LOOP_END = 5'd12;
	localparam pc_t PC_NUM      = 5'd13;
	localparam pc_t PC_DIV      = 5'd14;
	localparam pc_t PC_DIV_END  = 5'd18;
	localparam pc_t PC_TERM     = 5'd19;
	localparam pc_t PC_FIN      = 5'd20;

	typedef struct packed {
		op_t  op;
		logic mul_en;
		sel_t a_sel;
		sel_t b_sel;
		logic a_hi;
		logic b_hi;
		logic acc_en;
		logic acc_clr;
		logic acc_half;
		jmp_t jmp;
		pc_t  target;
	} ctrl_t;

	function automatic logic [OPD_W-1:0] recip_of(input logic [TBL_IW-1:0] k);
		return RECIP_TBL[k];
	endfunction

	function automatic logic [11:0] half_d_of(input logic [TBL_IW-1:0] k);
		return HALF_D_TBL[k];
	endfunction

	// 64x64 product as four 32x32 partial products, registered, then accumulated
	function automatic ctrl_t mac_word(input logic [2:0] s, input sel_t a, input sel_t b,
			input logic half);
		ctrl_t c;
		c          = '0;
		c.op       = OP_NOP;
		c.jmp      = J_NEXT;
		c.target   = PC_IDLE;
		c.mul_en   = (s < 3'd4);
		c.a_sel    = a;
		c.b_sel    = b;
		c.a_hi     = s[1];
		c.b_hi     = s[0];
		c.acc_en   = (s != 3'd0);
		c.acc_clr  = (s == 3'd1);
		c.acc_half = half;
		return c;
	endfunction

	function automatic ctrl_t ucode(input pc_t pc);
		ctrl_t c;
		c        = '0;
		c.op     = OP_NOP;
		c.jmp    = J_NEXT;
		c.target = PC_IDLE;
		unique case (pc) inside
			PC_IDLE: begin
				c.op  = OP_LOAD;
				c.jmp = J_WAIT_IN;
			end
			PC_RED: begin
				c.op  = OP_RED;
				c.jmp = J_RED;
			end
			[PC_RSQ:PC_RSQ_END]:   c = mac_word(3'(pc - PC_RSQ), A_REM, B_REM, 1'b1);
			PC_R2: begin
				c.op     = OP_R2;
				c.jmp    = J_ONE_TERM;
				c.target = PC_FIN;
			end
			[PC_LOOP:PC_LOOP_END]: c = mac_word(3'(pc - PC_LOOP), A_TERM, B_R2, 1'b1);
			PC_NUM:                c.op = OP_NUM;
			[PC_DIV:PC_DIV_END]:   c = mac_word(3'(pc - PC_DIV), A_NUM, B_RECIP, 1'b0);
			PC_TERM: begin
				c.op     = OP_TERM;
				c.jmp    = J_LOOP;
				c.target = PC_LOOP;
			end
			PC_FIN: begin
				c.op     = OP_FIN;
				c.jmp    = J_WAIT_OUT;
				c.target = PC_IDLE;
			end
			default: begin
				c.jmp    = J_WAIT_OUT;
				c.target = PC_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

FILE: design/cosine_taylor_series_core.sv
// cosine_taylor_series_core.sv
// Fixed-point cosine: range reduction by 2*pi, then a Taylor series run by microcode.
// Depends on cts_pkg.
//
// Input channel in_valid/in_ready carries angle, signed Q8.24 radians; output channel
// out_valid/out_ready carries cosine, signed Q2.30, one result per input transaction.
// Configuration channel cfg_valid/cfg_ready writes terms_used (0 acts as 1, values
// above 16 act as 16); cfg_ready is always high, write only while the core is idle.
// One item is in flight at a time; the next is taken the cycle after its result is
// loaded. The term loop sets the latency: each term needs two products, t*r^2 and
// the reciprocal multiply that divides by (2k)(2k-1), both on the one shared 32x32
// multiplier. Range reduction is 5 restoring steps.
// A finished result waits in the output register; an input is still accepted then,
// and the core only holds in its last step while the register is full and stalled.
// Reset (arst_n low) clears the sequencer and output valid, and sets terms_used to 16.
module cosine_taylor_series_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [cts_pkg::ANGLE_W-1:0] angle,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [cts_pkg::COS_W-1:0]   cosine,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic        [cts_pkg::CFG_W-1:0]   terms_used
);
	import cts_pkg::*;

	pc_t                    pc_q, pc_next;
	ctrl_t                  cw;
	logic [CFG_W-1:0]       terms_q;
	logic [CNT_W-1:0]       n_q, k_q, n_load;
	logic [X_W-1:0]         rem_q, x_mag, red_div;
	logic [ANGLE_W-1:0]     ang_mag;
	logic [R2_W-1:0]        r2_q;
	logic [TERM_W-1:0]      term_mag_q, quo;
	logic                   term_neg_q;
	logic [NUM_W-1:0]       num_q;
	logic signed [SUM_W-1:0] sum_q, term_add;
	logic [OPD_W-1:0]       opa, opb, pp_q;
	logic [MUL_W-1:0]       a_part, b_part;
	logic [1:0]             pw_q;
	logic [ACC_W-1:0]       acc_q, acc_base, acc_add;
	logic                   out_valid_q, out_free, in_fire, fin_fire;
	logic signed [COS_W-1:0] cosine_q, cos_next;
	logic [SUM_W-1:0]       sum_mag, sum_rnd;
	logic [SUM_W-RND_SH-1:0] m;

	assign cw        = ucode(pc_q);
	assign in_ready  = (pc_q == PC_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign fin_fire  = (cw.op == OP_FIN) && out_free;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign cosine    = cosine_q;

	// sequencer
	always_comb begin
		pc_next = pc_q + 1'b1;
		unique case (cw.jmp)
			J_NEXT:     pc_next = pc_q + 1'b1;
			J_WAIT_IN:  pc_next = in_fire ? pc_q + 1'b1 : pc_q;
			J_RED:      pc_next = (k_q == '0) ? pc_q + 1'b1 : pc_q;
			J_ONE_TERM: pc_next = (n_q == CNT_W'(1)) ? cw.target : pc_q + 1'b1;
			J_LOOP:     pc_next = ((k_q + 1'b1) < n_q) ? cw.target : pc_q + 1'b1;
			J_WAIT_OUT: pc_next = out_free ? cw.target : pc_q;
			default:    pc_next = PC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= PC_IDLE;
			terms_q <= TERMS_RESET;
		end else begin
			pc_q <= pc_next;
			if (cfg_valid)
				terms_q <= terms_used;
		end
	end

	// input conversion
	assign ang_mag = angle[ANGLE_W-1] ? ANGLE_W'(-angle) : ANGLE_W'(angle);
	assign x_mag   = X_W'(ang_mag) << (Q_FRAC - ANGLE_FRAC_BITS);

	always_comb begin
		if (terms_q == '0)
			n_load = CNT_W'(1);
		else if ({1'b0, terms_q} > (CFG_W + 1)'(MAX_TERMS))
			n_load = CNT_W'(MAX_TERMS);
		else
			n_load = CNT_W'(terms_q);
	end

	assign red_div = X_W'(TWO_PI_Q40) << k_q;

	// shared multiplier operands
	always_comb begin
		case (cw.a_sel)
			A_REM:   opa = OPD_W'(rem_q);
			A_TERM:  opa = OPD_W'(term_mag_q);
			A_NUM:   opa = OPD_W'(num_q);
			default: opa = '0;
		endcase
		case (cw.b_sel)
			B_REM:   opb = OPD_W'(rem_q);
			B_R2:    opb = OPD_W'(r2_q);
			B_RECIP: opb = recip_of(TBL_IW'(k_q));
			default: opb = '0;
		endcase
	end

	assign a_part   = cw.a_hi ? opa[OPD_W-1:MUL_W] : opa[MUL_W-1:0];
	assign b_part   = cw.b_hi ? opb[OPD_W-1:MUL_W] : opb[MUL_W-1:0];
	assign acc_base = cw.acc_half ? (ACC_W'(1) << (Q_FRAC - 1)) : '0;
	assign acc_add  = ACC_W'(pp_q) << (pw_q * MUL_W);

	assign quo      = acc_q[OPD_W +: TERM_W];
	assign term_add = term_neg_q ? SUM_W'(quo) : -SUM_W'(quo);

	always_ff @(posedge clk) begin
		if (cw.mul_en) begin
			pp_q <= a_part * b_part;
			pw_q <= {1'b0, cw.a_hi} + {1'b0, cw.b_hi};
		end
		if (cw.acc_en)
			acc_q <= (cw.acc_clr ? acc_base : acc_q) + acc_add;
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= '0;
			n_q        <= CNT_W'(1);
			term_neg_q <= 1'b0;
		end else begin
			case (cw.op)
				OP_LOAD: begin
					if (in_fire) begin
						rem_q      <= x_mag;
						k_q        <= CNT_W'(RED_STEPS - 1);
						n_q        <= n_load;
						sum_q      <= ONE_Q40;
						term_mag_q <= TERM_W'(ONE_Q40);
						term_neg_q <= 1'b0;
					end
				end
				OP_RED: begin
					if (rem_q >= red_div)
						rem_q <= rem_q - red_div;
					k_q <= k_q - 1'b1;
				end
				OP_R2: begin
					r2_q <= acc_q[Q_FRAC +: R2_W];
					k_q  <= CNT_W'(1);
				end
				OP_NUM: num_q <= acc_q[Q_FRAC +: NUM_W] + NUM_W'(half_d_of(TBL_IW'(k_q)));
				OP_TERM: begin
					term_mag_q <= quo;
					term_neg_q <= ~term_neg_q;
					sum_q      <= sum_q + term_add;
					k_q        <= k_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Q.40 sum to Q2.30, round half away from zero, saturate
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign sum_rnd = sum_mag + (SUM_W'(1) << (RND_SH - 1));
	assign m       = sum_rnd[SUM_W-1:RND_SH];

	always_comb begin
		if (sum_q[SUM_W-1]) begin
			if (m > (SUM_W - RND_SH)'(1) << (COS_W - 1))
				cos_next = {1'b1, {(COS_W-1){1'b0}}};
			else
				cos_next = COS_W'(-m);
		end else begin
			if (m > {(COS_W-1){1'b1}})
				cos_next = {1'b0, {(COS_W-1){1'b1}}};
			else
				cos_next = COS_W'(m);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fin_fire)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_fire)
			cosine_q <= cos_next;
	end

endmodule

FILE: design/cts_checker.sv
// cts_checker.sv
// Port-level checks of the cosine core, bound to its top level.
// Depends on cosine_taylor_series_core_defines.svh.
`include "cosine_taylor_series_core_defines.svh"

module cts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] cosine
);

	`CTS_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(cosine), "result changed while stalled")
	`CTS_ASSERT(a_busy_after_in, clk, arst_n, in_valid && in_ready |=> !in_ready && !$rose(out_valid), "core not busy after input transaction")
	`CTS_ASSERT(a_idle_at_result, clk, arst_n, $rose(out_valid) |-> in_ready, "new result without returning to idle")
	`CTS_ASSERT_ALWAYS(a_reset_state, clk, !arst_n |=> !out_valid && in_ready, "reset state wrong")

endmodule

bind cosine_taylor_series_core cts_checker u_cts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.cosine    (cosine)
);
